// ===== rtl/tga_pkg.sv =====
// shared constants, cordic table and stage types for the grazing angle pipeline
package tga_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int STAGES        = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int VW            = 52;
  localparam int ZW            = 33;
  localparam int SPW           = 12;
  localparam int LATENCY       = 2 * STAGES + 2;

  localparam logic [SPW-1:0] SPACING_RESET = 12'd30;
  localparam logic [30:0]    GAIN_Q30      = 31'd1768195363;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef logic signed [VW-1:0] vec_word_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef struct packed {
    vec_word_t             x;
    vec_word_t             y;
    logic signed [ZW-1:0]  z;
    logic [15:0]           elev;
  } rot_t;

  typedef struct packed {
    vec_word_t   x;
    vec_word_t   y;
    logic [31:0] slope;
    logic [15:0] elev;
  } vec_t;

endpackage

// ===== rtl/tga_prerot.sv =====
// input stage: central differences and exact quarter-turn pre-rotation
module tga_prerot
  import tga_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [15:0] row_after_height,
  input  logic signed [15:0] row_before_height,
  input  logic signed [15:0] col_after_height,
  input  logic signed [15:0] col_before_height,
  input  logic [15:0]        azimuth,
  input  logic signed [15:0] look_elevation,
  output logic               vld,
  output rot_t               q
);

  logic signed [16:0] drow;
  logic signed [16:0] dcol;
  logic signed [16:0] px;
  logic signed [16:0] py;
  logic [31:0]        theta;
  logic [31:0]        qsum;
  logic [31:0]        resid;
  quad_t              quad;
  rot_t               q_next;

  always_comb begin
    drow  = {row_after_height[15], row_after_height} - {row_before_height[15], row_before_height};
    dcol  = {col_after_height[15], col_after_height} - {col_before_height[15], col_before_height};
    theta = 32'd0 - {azimuth, 16'd0};
    qsum  = theta + 32'h2000_0000;
    quad  = quad_t'(qsum[31:30]);
    resid = theta - {qsum[31:30], 30'd0};
    case (quad)
      QUAD_1: begin
        px = -drow;
        py = dcol;
      end
      QUAD_2: begin
        px = -dcol;
        py = -drow;
      end
      QUAD_3: begin
        px = drow;
        py = -dcol;
      end
      default: begin
        px = dcol;
        py = drow;
      end
    endcase
    // height differences enter scaled by 2^30
    q_next.x    = {{(VW-47){px[16]}}, px, 30'd0};
    q_next.y    = {{(VW-47){py[16]}}, py, 30'd0};
    q_next.z    = {{(ZW-32){resid[31]}}, resid};
    q_next.elev = look_elevation;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/tga_rotate.sv =====
// cordic rotation pipeline, one iteration per register stage
module tga_rotate
  import tga_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_vld,
  input  rot_t in_d,
  output logic out_vld,
  output rot_t out_d
);

  logic vld [STAGES];
  rot_t st  [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic prev_v;
    rot_t cur;
    rot_t nxt;
    logic signed [ZW-1:0] ang;

    if (i == 0) begin : g_first
      assign prev_v = in_vld;
      assign cur    = in_d;
    end else begin : g_rest
      assign prev_v = vld[i-1];
      assign cur    = st[i-1];
    end

    always_comb begin
      ang      = {{(ZW-32){1'b0}}, ATAN_TURNS[i]};
      nxt.elev = cur.elev;
      if (!cur.z[ZW-1]) begin
        nxt.x = cur.x - (cur.y >>> i);
        nxt.y = cur.y + (cur.x >>> i);
        nxt.z = cur.z - ang;
      end else begin
        nxt.x = cur.x + (cur.y >>> i);
        nxt.y = cur.y - (cur.x >>> i);
        nxt.z = cur.z + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[i] <= nxt;
      end
    end
  end

  assign out_vld = vld[STAGES-1];
  assign out_d   = st[STAGES-1];

endmodule

// ===== rtl/tga_vector.sv =====
// cordic vectoring pipeline, accumulates the slope angle
module tga_vector
  import tga_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      in_vld,
  input  rot_t      in_d,
  input  vec_word_t den,
  output logic      out_vld,
  output vec_t      out_d
);

  logic vld [STAGES];
  vec_t st  [STAGES];
  vec_t head;

  // numerator goes to y, spacing term to x
  always_comb begin
    head.x     = den;
    head.y     = in_d.x;
    head.slope = 32'd0;
    head.elev  = in_d.elev;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic prev_v;
    vec_t cur;
    vec_t nxt;

    if (i == 0) begin : g_first
      assign prev_v = in_vld;
      assign cur    = head;
    end else begin : g_rest
      assign prev_v = vld[i-1];
      assign cur    = st[i-1];
    end

    always_comb begin
      nxt.elev = cur.elev;
      if (!cur.y[VW-1]) begin
        nxt.x     = cur.x + (cur.y >>> i);
        nxt.y     = cur.y - (cur.x >>> i);
        nxt.slope = cur.slope + ATAN_TURNS[i];
      end else begin
        nxt.x     = cur.x - (cur.y >>> i);
        nxt.y     = cur.y + (cur.x >>> i);
        nxt.slope = cur.slope - ATAN_TURNS[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[i] <= nxt;
      end
    end
  end

  assign out_vld = vld[STAGES-1];
  assign out_d   = st[STAGES-1];

endmodule

// ===== rtl/terrain_grazing_angle_top.sv =====
// grazing angle top level: spacing register, pipeline, output register
//
// Takes one map cell per cycle while in_stall is low. A cell passes 2*CORDIC_STAGES+2 register
// stages (34 with 16 stages): one input register, one register per cordic rotation
// iteration, one per vectoring iteration and the output register. The pipeline moves as
// one; it holds only while a result sits in the output register and out_stall is high,
// and in_stall mirrors exactly that. The grid spacing register is written through the
// cfg channel (always ready). A new spacing reaches the vectoring head through the
// grid_spacing and den registers, so cells already in flight may see it: write only
// while no cell is in flight.
module terrain_grazing_angle_top
  import tga_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] row_after_height,
  input  logic signed [15:0] row_before_height,
  input  logic signed [15:0] col_after_height,
  input  logic signed [15:0] col_before_height,
  input  logic [15:0]        azimuth,
  input  logic signed [15:0] look_elevation,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] grazing_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SPW-1:0]     cfg_data
);

  logic            adv;
  logic [SPW-1:0]  grid_spacing;
  logic [SPW-1:0]  sp_eff;
  logic [43:0]     den_prod;
  vec_word_t       den;
  logic            pre_vld;
  rot_t            pre_d;
  logic            rot_vld;
  rot_t            rot_d;
  logic            vec_vld;
  vec_t            vec_d;
  logic [31:0]     rounded;
  logic [15:0]     grazing_next;

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_spacing <= SPACING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      grid_spacing <= cfg_data;
    end
  end

  // zero spacing counts as one post
  always_comb begin
    sp_eff   = (grid_spacing == '0) ? SPW'(1) : grid_spacing;
    den_prod = 44'({sp_eff, 1'b0}) * 44'(GAIN_Q30);
  end

  always_ff @(posedge clk) begin
    den <= {{(VW-44){1'b0}}, den_prod};
  end

  tga_prerot u_prerot (
    .clk               (clk),
    .rst               (rst),
    .adv               (adv),
    .in_valid          (in_valid),
    .row_after_height  (row_after_height),
    .row_before_height (row_before_height),
    .col_after_height  (col_after_height),
    .col_before_height (col_before_height),
    .azimuth           (azimuth),
    .look_elevation    (look_elevation),
    .vld               (pre_vld),
    .q                 (pre_d)
  );

  tga_rotate u_rotate (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (pre_vld),
    .in_d    (pre_d),
    .out_vld (rot_vld),
    .out_d   (rot_d)
  );

  tga_vector u_vector (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (rot_vld),
    .in_d    (rot_d),
    .den     (den),
    .out_vld (vec_vld),
    .out_d   (vec_d)
  );

  // round slope to 16 bits, ties up, then subtract elevation mod a turn
  always_comb begin
    rounded      = vec_d.slope + 32'h0000_8000;
    grazing_next = rounded[31:16] - vec_d.elev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vec_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grazing_angle <= grazing_next;
    end
  end

endmodule

// ===== rtl/tga_checker.sv =====
// port-level checks of the grazing angle block, bound to the top level
module tga_checker
  import tga_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] grazing_angle,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  logic [7:0] pending;

  // requests inside the block, accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(in_valid && !in_stall) - 8'(out_valid && !out_stall);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(grazing_angle))
    else $error("stalled result changed or dropped");

  a_stall_map: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && pending == '0)
    else $error("result present right after reset");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 8'(LATENCY) && (!out_valid || pending != '0))
    else $error("more requests in flight than pipeline depth");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind terrain_grazing_angle_top tga_checker u_tga_checker (.*);

// ===== tb/sv/terrain_grazing_angle_top_tb.sv =====
// testbench for the grazing angle pipeline: directed table, random cells, self-checking
`timescale 1ns / 100ps

module terrain_grazing_angle_top_tb;
  import tga_pkg::*;

  localparam int PASSES = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam longint K_Q30 = 64'sd1768195363;
  localparam int CELLS_PER_PHASE = 106;
  localparam int PHASES = 9;
  localparam int HOLD_CYCLES = 150;

  // atan(2^-i), 2^32 per turn
  localparam logic [31:0] ARCTAN_STEPS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [15:0] row_after;
    logic signed [15:0] row_before;
    logic signed [15:0] col_after;
    logic signed [15:0] col_before;
    logic [15:0]        azimuth;
    logic signed [15:0] elev;
  } cell_t;

  typedef struct packed {
    cell_t       stim;
    logic        known;
    logic [15:0] answer;
  } steer_row_t;

  typedef enum logic [1:0] {
    FREE_FLOW,
    RANDOM_STALL,
    EVERY_THIRD,
    STALL_RUNS
  } stall_mode_t;

  // row_after, row_before, col_after, col_before, azimuth, elevation, known, answer
  localparam steer_row_t DIRECTED [22] = '{
    {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000},
    {16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h4000, 16'h8000, 1'b1, 16'h8000},
    {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 1'b1, 16'h8001},
    {16'h0064, 16'h0064, 16'h0064, 16'h0064, 16'h1234, 16'h0001, 1'b1, 16'hFFFF},
    {16'hFFFB, 16'hFFFB, 16'hFFFB, 16'hFFFB, 16'h8000, 16'hFFFF, 1'b1, 16'h0001},
    {16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 1'b0, 16'h0000},
    {16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 1'b0, 16'h0000},
    {16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
    {16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h4000, 1'b0, 16'h0000},
    {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h2000, 16'h0000, 1'b0, 16'h0000},
    {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hE000, 16'h8000, 1'b0, 16'h0000},
    {16'h000A, 16'hFFF6, 16'h0014, 16'hFFEC, 16'h1FFF, 16'h0000, 1'b0, 16'h0000},
    {16'h000A, 16'hFFF6, 16'h0014, 16'hFFEC, 16'h2001, 16'h0000, 1'b0, 16'h0000},
    {16'h000A, 16'hFFF6, 16'h0014, 16'hFFEC, 16'h6000, 16'h0100, 1'b0, 16'h0000},
    {16'h000A, 16'hFFF6, 16'h0014, 16'hFFEC, 16'hA000, 16'hFF00, 1'b0, 16'h0000},
    {16'h000A, 16'hFFF6, 16'h0014, 16'hFFEC, 16'hC000, 16'h0000, 1'b0, 16'h0000},
    {16'h0032, 16'h0000, 16'hFFCE, 16'h0000, 16'h0001, 16'h7FFF, 1'b0, 16'h0000},
    {16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 1'b0, 16'h0000},
    {16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
    {16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC, 16'h5A5A, 16'hA5A5, 1'b0, 16'h0000},
    {16'hAAAA, 16'h5555, 16'hCCCC, 16'h3333, 16'hA5A5, 16'h5A5A, 1'b0, 16'h0000},
    {16'h001E, 16'hFFE2, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 1'b0, 16'h0000}
  };

  localparam logic [SPW-1:0] SPACING_PLAN [6] = '{
    12'd0, 12'd1, 12'd4095, 12'd30, 12'd2048, 12'd17
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] row_after_height;
  logic signed [15:0] row_before_height;
  logic signed [15:0] col_after_height;
  logic signed [15:0] col_before_height;
  logic [15:0]        azimuth;
  logic signed [15:0] look_elevation;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] grazing_angle;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SPW-1:0]     cfg_data;

  logic [15:0]    grazing_due [$];
  logic [SPW-1:0] spacing_now;
  int             mismatches;
  int             requests_sent;
  int             burst_left;
  bit             hold_done;

  terrain_grazing_angle_top DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .row_after_height  (row_after_height),
    .row_before_height (row_before_height),
    .col_after_height  (col_after_height),
    .col_before_height (col_before_height),
    .azimuth           (azimuth),
    .look_elevation    (look_elevation),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .grazing_angle     (grazing_angle),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // expected grazing angle of one cell at the given post spacing
  function automatic logic [15:0] grazing_of(cell_t c, logic [SPW-1:0] spacing);
    longint      drow;
    longint      dcol;
    longint      x;
    longint      y;
    longint      t;
    longint      z;
    longint      sp;
    logic [31:0] theta;
    logic [31:0] shifted;
    logic [31:0] resid;
    logic [31:0] slope;
    quad_t       quad;
    drow = longint'(c.row_after) - longint'(c.row_before);
    dcol = longint'(c.col_after) - longint'(c.col_before);
    theta = 32'd0 - {c.azimuth, 16'h0000};
    shifted = theta + 32'h2000_0000;
    quad = quad_t'(shifted[31:30]);
    resid = theta - {shifted[31:30], 30'd0};
    // exact quarter-turn step first, cordic only removes the residual
    case (quad)
      QUAD_1: begin
        x = -drow;
        y = dcol;
      end
      QUAD_2: begin
        x = -dcol;
        y = -drow;
      end
      QUAD_3: begin
        x = drow;
        y = -dcol;
      end
      default: begin
        x = dcol;
        y = drow;
      end
    endcase
    x = x * (64'sd1 <<< 30);
    y = y * (64'sd1 <<< 30);
    z = longint'($signed(resid));
    for (int i = 0; i < PASSES; i++) begin
      t = x;
      if (z >= 0) begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z = z - longint'({32'd0, ARCTAN_STEPS[i]});
      end else begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z = z + longint'({32'd0, ARCTAN_STEPS[i]});
      end
    end
    sp = (spacing == '0) ? 64'sd1 : longint'({52'd0, spacing});
    // both sides carry the cordic gain, so it cancels in the angle
    y = x;
    x = 2 * sp * K_Q30;
    slope = 32'd0;
    for (int i = 0; i < PASSES; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        slope = slope + ARCTAN_STEPS[i];
      end else begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        slope = slope - ARCTAN_STEPS[i];
      end
    end
    slope = slope + 32'h0000_8000;
    return slope[31:16] - c.elev;
  endfunction

  function automatic logic [15:0] extreme_height();
    case ($urandom_range(3, 0))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    int    base;
    int    reach;
    int    kind;
    kind = $urandom_range(9, 0);
    reach = (kind >= 8) ? 6000 : 200;
    base = int'($urandom_range(50000, 0)) - 25000;
    case (kind)
      0, 1: begin
        c.row_after  = 16'($urandom);
        c.row_before = 16'($urandom);
        c.col_after  = 16'($urandom);
        c.col_before = 16'($urandom);
      end
      6: begin
        c.row_after  = extreme_height();
        c.row_before = extreme_height();
        c.col_after  = extreme_height();
        c.col_before = extreme_height();
      end
      7: begin
        c.row_after  = 16'($urandom);
        c.row_before = c.row_after;
        c.col_after  = c.row_after;
        c.col_before = c.row_after;
      end
      default: begin
        // neighbours scattered around a common base height
        c.row_after  = 16'(base + int'($urandom_range(2 * reach, 0)) - reach);
        c.row_before = 16'(base + int'($urandom_range(2 * reach, 0)) - reach);
        c.col_after  = 16'(base + int'($urandom_range(2 * reach, 0)) - reach);
        c.col_before = 16'(base + int'($urandom_range(2 * reach, 0)) - reach);
      end
    endcase
    if ($urandom_range(3, 0) == 0)
      c.azimuth = {3'($urandom_range(7, 0)), 13'h0000} + 16'($urandom_range(4, 0)) - 16'd2;
    else
      c.azimuth = 16'($urandom);
    if ($urandom_range(1, 0) == 0)
      c.elev = 16'($urandom);
    else
      c.elev = 16'($urandom_range(2048, 0)) - 16'd1024;
    return c;
  endfunction

  // offer one request and hold it until taken; ends a burst with a random gap
  task automatic offer_cell(input cell_t c, input logic [15:0] want, input bit phase_end);
    int gap;
    row_after_height  <= c.row_after;
    row_before_height <= c.row_before;
    col_after_height  <= c.col_after;
    col_before_height <= c.col_before;
    azimuth           <= c.azimuth;
    look_elevation    <= c.elev;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall);
    grazing_due.push_back(want);
    requests_sent++;
    if (burst_left == 0 || phase_end) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(40, 1) - 1;
      gap = $urandom_range(8, 1);
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    while (grazing_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [SPW-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    spacing_now = value;
  endtask

  // receiver: segments of different stall patterns, plus one long hold-off
  initial begin
    stall_mode_t mode;
    int          seg;
    int          run;
    logic        run_stall;
    out_stall = 1'b0;
    run = 0;
    run_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      if (!hold_done && requests_sent >= 200) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = stall_mode_t'($urandom_range(3, 0));
      seg = $urandom_range(80, 16);
      for (int k = 0; k < seg; k++) begin
        case (mode)
          FREE_FLOW:    out_stall <= 1'b0;
          RANDOM_STALL: out_stall <= ($urandom_range(3, 0) == 0);
          EVERY_THIRD:  out_stall <= (k % 3 == 2);
          default: begin
            if (run == 0) begin
              run = $urandom_range(8, 1);
              run_stall = 1'($urandom_range(1, 0));
            end
            run--;
            out_stall <= run_stall;
          end
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (grazing_due.size() == 0) begin
        $error("grazing_angle: result with none expected, got %0d", grazing_angle);
        mismatches++;
      end else begin
        want = grazing_due.pop_front();
        if (grazing_angle !== want) begin
          $error("grazing_angle mismatch: expected %0d, actual %0d",
                 $signed(want), grazing_angle);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cell_t       c;
    logic [15:0] want;
    rst               = 1'b1;
    in_valid          = 1'b0;
    row_after_height  = '0;
    row_before_height = '0;
    col_after_height  = '0;
    col_before_height = '0;
    azimuth           = '0;
    look_elevation    = '0;
    cfg_valid         = 1'b0;
    cfg_data          = '0;
    spacing_now       = SPACING_RESET;
    mismatches        = 0;
    requests_sent     = 0;
    burst_left        = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed cells at the reset spacing
    foreach (DIRECTED[r]) begin
      c = DIRECTED[r].stim;
      want = DIRECTED[r].known ? DIRECTED[r].answer : grazing_of(c, spacing_now);
      offer_cell(c, want, r == $size(DIRECTED) - 1);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_spacing(p < 6 ? SPACING_PLAN[p] : SPW'($urandom_range(4095, 1)));
      for (int n = 0; n < CELLS_PER_PHASE; n++) begin
        c = random_cell();
        offer_cell(c, grazing_of(c, spacing_now), n == CELLS_PER_PHASE - 1);
      end
    end

    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && grazing_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tga_pkg.sv
rtl/tga_prerot.sv
rtl/tga_rotate.sv
rtl/tga_vector.sv
rtl/terrain_grazing_angle_top.sv
rtl/tga_checker.sv
tb/sv/terrain_grazing_angle_top_tb.sv
